[rtl/rec_pkg.sv]
// Package with the constants and types shared by the red-excess centroid block.
package rec_pkg;

  localparam int unsigned COLUMNS       = 128;
  localparam int unsigned ROWS          = 128;
  localparam int unsigned FRACTION_BITS = 8;

  localparam int unsigned COL_W   = $clog2(COLUMNS);
  localparam int unsigned ROW_W   = $clog2(ROWS);
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned WSUM_W  = 29;
  localparam int unsigned LSUM_W  = 22;
  localparam int unsigned CENT_W  = 15;
  localparam int unsigned NUM_W   = WSUM_W + 4 + FRACTION_BITS;
  localparam int unsigned DEN_W   = LSUM_W + 4;
  localparam int unsigned CNT_W   = $clog2(NUM_W + 1);
  localparam int unsigned IN_W    = 3 * LEVEL_W;
  localparam int unsigned OUT_RAW = LEVEL_W + CENT_W + LSUM_W;
  localparam int unsigned OUT_W   = ((OUT_RAW + 7) / 8) * 8;

  localparam logic [CENT_W-1:0] CENTROID_MAX = {CENT_W{1'b1}};

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[rtl/rec_div.sv]
// Iterative restoring divider that yields one quotient bit per clock cycle.
module rec_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rec_pkg::NUM_W-1:0] num_i,
  input  logic [rec_pkg::DEN_W-1:0] den_i,
  output rec_pkg::div_stat_t        stat_o,
  output logic [rec_pkg::NUM_W-1:0] quo_o
);
  import rec_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W-1:0] rem_sub;
  logic             ge;

  assign rem_sh  = {rem_q, quo_q[NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh[DEN_W-1:0] - den_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (busy_q) begin
      quo_d = {quo_q[NUM_W-2:0], ge};
      rem_d = ge ? rem_sub : rem_sh[DEN_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W);
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("divider done without a preceding run");
  a_cnt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0)
    else $error("divider running with an empty count");
  a_start_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_q) |=> busy_q && cnt_q == CNT_W'(NUM_W))
    else $error("divider start not taken");
`endif

endmodule

[rtl/red_excess_centroid_x.sv]
// Top level of the red-excess level and horizontal centroid block.
// Pixels arrive on the slave stream one word each, in raster order over a
// frame of 128 by 128 pixels. Every pixel gives one result word on the master
// stream with its red-excess level. The result of an ordinary pixel is
// registered, so it appears in the cycle after acceptance. The last pixel
// of a frame raises tlast and carries the total level and the centroid;
// the centroid comes from a restoring divider that works out one quotient
// bit per cycle, and while that pixel is processed tready stays low. A
// stalled result word holds in the output register and further pixels are
// refused until it is taken; the next pixel may be accepted in the cycle in
// which the held word leaves. Reset clears the position counters, the frame
// sums and the output valid flag, so the block starts at the first pixel of
// a new frame.
module red_excess_centroid_x (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // blue [7:0], green [15:8], red [23:16]
  input  logic [rec_pkg::IN_W-1:0]    s_axis_tdata_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // red_level [7:0], centroid_x [22:8], total_level [44:23], zero [47:45]
  output logic [rec_pkg::OUT_W-1:0]   m_axis_tdata_o,
  // frame_done
  output logic                        m_axis_tlast_o
);
  import rec_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_LOAD  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [WSUM_W-1:0]  wsum_q, wsum_d;
  logic [LSUM_W-1:0]  lsum_q, lsum_d;
  logic [LEVEL_W-1:0] last_level_q, last_level_d;
  logic [LSUM_W-1:0]  total_q, total_d;
  logic               out_valid_q, out_valid_d;
  logic               out_last_q, out_last_d;
  logic [OUT_W-1:0]   out_data_q, out_data_d;

  logic [LEVEL_W-1:0] blue, green, red;
  logic [LEVEL_W:0]   gb_sum;
  logic [LEVEL_W-1:0] diff;
  logic [LEVEL_W-1:0] level;
  logic [COL_W+LEVEL_W-1:0] prod;
  logic [WSUM_W-1:0]  wsum_next;
  logic [LSUM_W-1:0]  lsum_next;
  logic               frame_last;
  logic               accept;
  logic               out_free;
  logic [WSUM_W+3:0]  w10;
  logic [DEN_W-1:0]   den;
  logic [NUM_W-1:0]   num;
  logic               div_start;
  div_stat_t          div_stat;
  logic [NUM_W-1:0]   quo;
  logic [CENT_W-1:0]  centroid;

  assign blue   = s_axis_tdata_i[LEVEL_W-1:0];
  assign green  = s_axis_tdata_i[2*LEVEL_W-1:LEVEL_W];
  assign red    = s_axis_tdata_i[3*LEVEL_W-1:2*LEVEL_W];
  assign gb_sum = {1'b0, green} + {1'b0, blue};
  assign diff   = red - gb_sum[LEVEL_W-1:0];
  assign level  = ({1'b0, red} > gb_sum) ? diff : '0;
  assign prod   = {{LEVEL_W{1'b0}}, col_q} * {{COL_W{1'b0}}, level};

  assign wsum_next  = wsum_q + WSUM_W'(prod);
  assign lsum_next  = lsum_q + LSUM_W'(level);
  assign frame_last = (col_q == COL_W'(COLUMNS - 1)) && (row_q == ROW_W'(ROWS - 1));

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign w10 = ({4'b0, wsum_q} << 3) + ({4'b0, wsum_q} << 1);
  assign num = NUM_W'({w10, {FRACTION_BITS{1'b0}}});
  assign den = ({4'b0, lsum_q} << 3) + ({4'b0, lsum_q} << 1) + DEN_W'(1);

  assign div_start = (state_q == ST_START);
  assign centroid  = (quo > NUM_W'(CENTROID_MAX)) ? CENTROID_MAX : quo[CENT_W-1:0];

  rec_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (den),
    .stat_o  (div_stat),
    .quo_o   (quo)
  );

  always_comb begin
    state_d      = state_q;
    col_d        = col_q;
    row_d        = row_q;
    wsum_d       = wsum_q;
    lsum_d       = lsum_q;
    last_level_d = last_level_q;
    total_d      = total_q;
    out_valid_d  = out_valid_q;
    out_last_d   = out_last_q;
    out_data_d   = out_data_q;
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          wsum_d = wsum_next;
          lsum_d = lsum_next;
          if (frame_last) begin
            last_level_d = level;
            col_d        = '0;
            row_d        = '0;
            state_d      = ST_START;
          end else begin
            if (col_q == COL_W'(COLUMNS - 1)) begin
              col_d = '0;
              row_d = row_q + ROW_W'(1);
            end else begin
              col_d = col_q + COL_W'(1);
            end
            out_valid_d = 1'b1;
            out_last_d  = 1'b0;
            out_data_d  = OUT_W'(level);
          end
        end
      end
      ST_START: begin
        total_d = lsum_q;
        wsum_d  = '0;
        lsum_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_last_d  = 1'b1;
          out_data_d  = OUT_W'({total_q, centroid, last_level_q});
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      wsum_q      <= '0;
      lsum_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      wsum_q      <= wsum_d;
      lsum_q      <= lsum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_level_q <= last_level_d;
    total_q      <= total_d;
    out_last_q   <= out_last_d;
    out_data_q   <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef SYNTHESIS
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> !s_axis_tready_o)
    else $error("pixel accepted while the divider runs");
  a_plain_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tlast_o) |-> m_axis_tdata_o[OUT_W-1:LEVEL_W] == '0)
    else $error("frame fields set on an ordinary word");
  a_last_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && frame_last) |=> state_q == ST_START && col_q == '0 && row_q == '0)
    else $error("last pixel did not start the centroid division");
  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == ST_DIV)
    else $error("divider finished outside the division state");
`endif

endmodule
